FILE: design/mswt_pkg.sv
// Package for the multi-slot watchdog table: item, result and command types,
// status and kind codes, and the reset values of the threshold registers.
// No dependencies; every other file of the block uses it.
package mswt_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int OWNER_BITS_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int SLOT_ID_W = 4;
  localparam int OWNER_W   = 16;
  localparam int TICK_W    = 32;
  localparam int CFG_W     = 32;

  localparam logic [TICK_W-1:0] WARN_RST  = 32'd5;
  localparam logic [TICK_W-1:0] FATAL_RST = 32'd60;

  typedef enum logic [1:0] {
    KIND_ARM   = 2'd0,
    KIND_FEED  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_CHECK = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_ARMED     = 3'd0,
    ST_FED       = 3'd1,
    ST_NOT_ARMED = 3'd2,
    ST_FULL      = 3'd3,
    ST_WARNING   = 3'd4,
    ST_FATAL     = 3'd5,
    ST_NONE      = 3'd6,
    ST_HALTED    = 3'd7
  } status_e;

  typedef enum logic {
    REG_WARN  = 1'b0,
    REG_FATAL = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    kind_e                kind;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [OWNER_W-1:0]   owner;
  } item_t;

  typedef struct packed {
    status_e              status;
    logic [SLOT_ID_W-1:0] slot;
    logic [OWNER_W-1:0]   slot_owner;
    logic [TICK_W-1:0]    elapsed;
    logic                 last;
  } result_t;

  typedef struct packed {
    kind_e                kind;
    logic                 feed_ok;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [OWNER_W-1:0]   owner;
  } cmd_t;

endpackage

FILE: design/multi_slot_watchdog_table.sv
// Top level of the multi-slot watchdog table: threshold registers, front end,
// command queue and back end. Depends on mswt_pkg, mswt_front, mswt_queue
// and mswt_back.
//
//   Channel  Ports                          Transfer
//   -------  -----------------------------  -----------------------------------
//   item     start, busy, item_i            taken when start is high, busy low
//   result   res_strobe_o, res_o            one cycle per result, no stall
//   config   cfg_we_i, cfg_idx_i,           written when cfg_we_i is high
//            cfg_wdata_i
//
// A tick advances the time from S_IDLE, a feed reads the slot tables and
// answers from S_FEED, an arm walks the valid bits one slot per cycle, and a
// check walks the slot tables through a read and stages p1 and p2 and sends its
// last result from S_DRAIN. Commands pass the two-entry queue; busy is high
// while it is full. Reset clears the valid bits, time and halt flag and loads
// the reset thresholds; the stamp and owner tables need no clearing pass.
module multi_slot_watchdog_table #(
  parameter int SLOTS      = mswt_pkg::SLOTS_DEF,
  parameter int OWNER_BITS = mswt_pkg::OWNER_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  mswt_pkg::item_t                item_i,
  output logic                           res_strobe_o,
  output mswt_pkg::result_t              res_o,
  input  logic                           cfg_we_i,
  input  mswt_pkg::cfg_reg_e             cfg_idx_i,
  input  logic [mswt_pkg::CFG_W-1:0]     cfg_wdata_i
);

  logic [mswt_pkg::TICK_W-1:0] warn_q;
  logic [mswt_pkg::TICK_W-1:0] fatal_q;
  mswt_pkg::cmd_t              front_cmd;
  mswt_pkg::cmd_t              head_cmd;
  logic                        q_empty;
  logic                        q_full;
  logic                        pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q  <= mswt_pkg::WARN_RST;
      fatal_q <= mswt_pkg::FATAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mswt_pkg::REG_WARN:  warn_q  <= cfg_wdata_i;
        mswt_pkg::REG_FATAL: fatal_q <= cfg_wdata_i;
        default: begin
          warn_q <= warn_q;
        end
      endcase
    end
  end

  assign busy = q_full;

  mswt_front #(
    .SLOTS      (SLOTS),
    .OWNER_BITS (OWNER_BITS)
  ) u_front (
    .item_i (item_i),
    .cmd_o  (front_cmd)
  );

  mswt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start && !q_full),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  mswt_back #(
    .SLOTS      (SLOTS),
    .OWNER_BITS (OWNER_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .warn_i       (warn_q),
    .fatal_i      (fatal_q),
    .cmd_valid_i  (!q_empty),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

FILE: design/mswt_front.sv
// Front end of the watchdog table: decodes an accepted item into a command.
// It checks the feed slot against the table size and masks the owner tag.
// Depends on mswt_pkg.
module mswt_front #(
  parameter int SLOTS      = mswt_pkg::SLOTS_DEF,
  parameter int OWNER_BITS = mswt_pkg::OWNER_BITS_DEF
) (
  input  mswt_pkg::item_t item_i,
  output mswt_pkg::cmd_t  cmd_o
);

  localparam int OwnW = mswt_pkg::OWNER_W;

  always_comb begin
    cmd_o.kind    = item_i.kind;
    cmd_o.slot_id = item_i.slot_id;
    cmd_o.feed_ok = (32'(item_i.slot_id) < 32'(SLOTS));
    for (int b = 0; b < OwnW; b++) begin
      cmd_o.owner[b] = (b < OWNER_BITS) ? item_i.owner[b] : 1'b0;
    end
  end

endmodule

FILE: design/mswt_queue.sv
// Short command queue between the front end and the execution back end.
// Depends on mswt_pkg for the command type and the queue depth.
module mswt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mswt_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output mswt_pkg::cmd_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int Depth = mswt_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  mswt_pkg::cmd_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: design/mswt_back.sv
// Back end of the watchdog table: slot tables, time counter and the walks
// for arm and check, with a registered result stage. Depends on mswt_pkg.
module mswt_back #(
  parameter int SLOTS      = mswt_pkg::SLOTS_DEF,
  parameter int OWNER_BITS = mswt_pkg::OWNER_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [mswt_pkg::TICK_W-1:0]     warn_i,
  input  logic [mswt_pkg::TICK_W-1:0]     fatal_i,
  input  logic                            cmd_valid_i,
  input  mswt_pkg::cmd_t                  cmd_i,
  output logic                            pop_o,
  output logic                            res_strobe_o,
  output mswt_pkg::result_t               res_o
);

  localparam int IdxW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WalkW    = $clog2(SLOTS + 2);
  localparam int CntW     = $clog2(mswt_pkg::MAX_RESULTS + 1);
  localparam int TickW    = mswt_pkg::TICK_W;
  localparam int OutOwnW  = mswt_pkg::OWNER_W;
  localparam int SlotOutW = mswt_pkg::SLOT_ID_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARM,
    S_FEED,
    S_CHECK,
    S_DRAIN
  } state_e;

  state_e                  state_q;
  logic [WalkW-1:0]        walk_q;
  logic [SLOTS-1:0]        valid_q;
  logic [TickW-1:0]        now_q;
  logic                    halted_q;
  logic [CntW-1:0]         cnt_q;
  logic                    pend_vld_q;
  mswt_pkg::result_t       pend_q;
  logic [SlotOutW-1:0]     feed_sid_q;
  logic [OutOwnW-1:0]      own_q;
  logic                    res_strobe_q;
  mswt_pkg::result_t       res_q;

  logic                    p1_vld_q;
  logic [IdxW-1:0]         p1_idx_q;
  logic                    p2_vld_q;
  logic [IdxW-1:0]         p2_idx_q;
  logic [OWNER_BITS-1:0]   p2_owner_q;
  logic [TickW-1:0]        p2_el_q;

  logic [TickW-1:0]        stamp_mem [SLOTS];
  logic [OWNER_BITS-1:0]   owner_mem [SLOTS];
  logic [TickW-1:0]        rd_stamp_q;
  logic [OWNER_BITS-1:0]   rd_owner_q;

  logic [IdxW-1:0]         walk_idx;
  logic [IdxW-1:0]         feed_idx;
  logic                    walk_issue;
  logic                    feed_hit;
  logic                    mem_we;
  logic                    rd_en;
  logic [IdxW-1:0]         rd_addr;
  logic                    p2_hit;
  logic                    p2_fat;
  logic                    stop;
  mswt_pkg::result_t       new_res;

  function automatic mswt_pkg::result_t make_res(mswt_pkg::status_e st,
                                                 logic [SlotOutW-1:0] sl,
                                                 logic [OutOwnW-1:0] ow,
                                                 logic [TickW-1:0] el,
                                                 logic lst);
    mswt_pkg::result_t r;
    r.status     = st;
    r.slot       = sl;
    r.slot_owner = ow;
    r.elapsed    = el;
    r.last       = lst;
    return r;
  endfunction

  assign walk_idx   = walk_q[IdxW-1:0];
  assign feed_idx   = IdxW'(cmd_i.slot_id);
  assign pop_o      = cmd_valid_i && (state_q == S_IDLE);
  assign walk_issue = (state_q == S_CHECK) && (walk_q < WalkW'(SLOTS));
  assign feed_hit   = cmd_i.feed_ok && valid_q[feed_idx];
  assign mem_we     = (state_q == S_ARM) && !valid_q[walk_idx];
  assign rd_en      = walk_issue ||
                      (pop_o && !halted_q && (cmd_i.kind == mswt_pkg::KIND_FEED) && feed_hit);
  assign rd_addr    = (state_q == S_IDLE) ? feed_idx : walk_idx;

  assign p2_hit  = p2_vld_q && (p2_el_q >= warn_i);
  assign p2_fat  = p2_hit && (p2_el_q >= fatal_i);
  assign stop    = p2_hit && (p2_fat || (cnt_q == CntW'(mswt_pkg::MAX_RESULTS - 1)));
  assign new_res = make_res(p2_fat ? mswt_pkg::ST_FATAL : mswt_pkg::ST_WARNING,
                            SlotOutW'(p2_idx_q), OutOwnW'(p2_owner_q), p2_el_q, 1'b0);

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      walk_q       <= '0;
      valid_q      <= '0;
      now_q        <= '0;
      halted_q     <= 1'b0;
      cnt_q        <= '0;
      pend_vld_q   <= 1'b0;
      pend_q       <= '0;
      p1_vld_q     <= 1'b0;
      p2_vld_q     <= 1'b0;
      res_strobe_q <= 1'b0;
      res_q        <= '0;
    end else begin
      res_strobe_q <= 1'b0;
      p1_vld_q     <= walk_issue && valid_q[walk_idx];
      p2_vld_q     <= (state_q == S_CHECK) && p1_vld_q;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (halted_q) begin
              res_strobe_q <= 1'b1;
              res_q <= make_res(mswt_pkg::ST_HALTED, '0, '0, '0, 1'b1);
            end else begin
              case (cmd_i.kind)
                mswt_pkg::KIND_ARM: begin
                  walk_q  <= '0;
                  state_q <= S_ARM;
                end
                mswt_pkg::KIND_FEED: begin
                  if (feed_hit) begin
                    valid_q[feed_idx] <= 1'b0;
                    state_q           <= S_FEED;
                  end else begin
                    res_strobe_q <= 1'b1;
                    res_q <= make_res(mswt_pkg::ST_NOT_ARMED, cmd_i.slot_id, '0, '0, 1'b1);
                  end
                end
                mswt_pkg::KIND_TICK: begin
                  now_q <= now_q + 1'b1;
                end
                mswt_pkg::KIND_CHECK: begin
                  walk_q     <= '0;
                  cnt_q      <= '0;
                  pend_vld_q <= 1'b0;
                  state_q    <= S_CHECK;
                end
                default: begin
                  state_q <= S_IDLE;
                end
              endcase
            end
          end
        end
        S_ARM: begin
          if (!valid_q[walk_idx]) begin
            valid_q[walk_idx] <= 1'b1;
            res_strobe_q      <= 1'b1;
            res_q   <= make_res(mswt_pkg::ST_ARMED, SlotOutW'(walk_idx), own_q, '0, 1'b1);
            state_q <= S_IDLE;
          end else if (walk_q == WalkW'(SLOTS - 1)) begin
            res_strobe_q <= 1'b1;
            res_q   <= make_res(mswt_pkg::ST_FULL, '0, '0, '0, 1'b1);
            state_q <= S_IDLE;
          end else begin
            walk_q <= walk_q + 1'b1;
          end
        end
        S_FEED: begin
          res_strobe_q <= 1'b1;
          res_q   <= make_res(mswt_pkg::ST_FED, feed_sid_q, OutOwnW'(rd_owner_q),
                              now_q - rd_stamp_q, 1'b1);
          state_q <= S_IDLE;
        end
        S_CHECK: begin
          walk_q <= walk_q + 1'b1;
          if (p2_hit) begin
            cnt_q      <= cnt_q + 1'b1;
            pend_q     <= new_res;
            pend_vld_q <= 1'b1;
            if (pend_vld_q) begin
              res_strobe_q <= 1'b1;
              res_q        <= pend_q;
            end
            if (p2_fat) begin
              halted_q <= 1'b1;
            end
          end
          if (stop || (walk_q == WalkW'(SLOTS + 1))) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          res_strobe_q <= 1'b1;
          if (pend_vld_q) begin
            res_q <= make_res(pend_q.status, pend_q.slot, pend_q.slot_owner,
                              pend_q.elapsed, 1'b1);
          end else begin
            res_q <= make_res(mswt_pkg::ST_NONE, '0, '0, '0, 1'b1);
          end
          pend_vld_q <= 1'b0;
          state_q    <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      feed_sid_q <= cmd_i.slot_id;
      own_q      <= cmd_i.owner;
    end
    if (mem_we) begin
      stamp_mem[walk_idx] <= now_q;
      owner_mem[walk_idx] <= OWNER_BITS'(own_q);
    end
    if (rd_en) begin
      rd_stamp_q <= stamp_mem[rd_addr];
      rd_owner_q <= owner_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    p1_idx_q   <= walk_idx;
    p2_idx_q   <= p1_idx_q;
    p2_owner_q <= rd_owner_q;
    p2_el_q    <= now_q - rd_stamp_q;
  end

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("Halted flag cleared without reset.");

  a_result_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (cnt_q < CntW'(mswt_pkg::MAX_RESULTS)))
    else $error("Check reported more slots than allowed.");

  a_halted_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && cmd_valid_i && halted_q) |=>
      (res_strobe_q && res_q.status == mswt_pkg::ST_HALTED && res_q.last))
    else $error("Halted block did not answer an item with halted.");

  a_partial_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_q && !res_q.last) |-> (state_q == S_CHECK || state_q == S_DRAIN))
    else $error("Non-final result outside of a check.");

endmodule

FILE: tb/sv/multi_slot_watchdog_table_test.sv
// Self-checking testbench for multi_slot_watchdog_table: a directed table of items,
// then random phases under several threshold settings, checked against a predictor.
// Depends on mswt_pkg and the multi_slot_watchdog_table RTL.
`timescale 1ns / 1ps

module multi_slot_watchdog_table_test;
  import mswt_pkg::*;

  localparam int NSLOT     = SLOTS_DEF;
  localparam int IDLE_CYC  = 2 * (NSLOT + 8);
  localparam int DRAIN_MAX = 4000;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  item_t              item_i = '0;
  logic               res_strobe_o;
  result_t            res_o;
  logic               cfg_we_i = 1'b0;
  cfg_reg_e           cfg_idx_i = REG_WARN;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;

  logic               slot_live [NSLOT];
  logic [TICK_W-1:0]  arm_stamp [NSLOT];
  logic [OWNER_W-1:0] arm_owner [NSLOT];
  logic [TICK_W-1:0]  now_cnt;
  logic [TICK_W-1:0]  warn_lim;
  logic [TICK_W-1:0]  fatal_lim;
  logic               frozen;

  result_t            owed_results [$];
  plan_row_t          plan [$];
  int                 fail_cnt = 0;
  bit                 calm = 1'b0;

  multi_slot_watchdog_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void predict_watchdog(input item_t it, ref result_t outs[$]);
    result_t     r;
    logic [31:0] el;
    int          hit;
    outs.delete();
    r = '0;
    r.last = 1'b1;
    if (frozen) begin
      r.status = ST_HALTED;
      outs.push_back(r);
      return;
    end
    case (it.kind)
      KIND_ARM: begin
        hit = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (hit < 0 && !slot_live[i]) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_live[hit] = 1'b1;
          arm_stamp[hit] = now_cnt;
          arm_owner[hit] = it.owner;
          r.status = ST_ARMED;
          r.slot = 4'(hit);
          r.slot_owner = it.owner;
        end
        outs.push_back(r);
      end
      KIND_FEED: begin
        r.slot = it.slot_id;
        if (slot_live[it.slot_id]) begin
          slot_live[it.slot_id] = 1'b0;
          r.status = ST_FED;
          r.slot_owner = arm_owner[it.slot_id];
          r.elapsed = now_cnt - arm_stamp[it.slot_id];
        end else begin
          r.status = ST_NOT_ARMED;
        end
        outs.push_back(r);
      end
      KIND_TICK: begin
        now_cnt = now_cnt + 1;
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!frozen && outs.size() < MAX_RESULTS && slot_live[i]) begin
            el = now_cnt - arm_stamp[i];
            if (el >= warn_lim) begin
              r.slot = 4'(i);
              r.slot_owner = arm_owner[i];
              r.elapsed = el;
              r.last = 1'b0;
              if (el >= fatal_lim) begin
                r.status = ST_FATAL;
                frozen = 1'b1;
              end else begin
                r.status = ST_WARNING;
              end
              outs.push_back(r);
            end
          end
        end
        if (outs.size() == 0) begin
          r = '0;
          r.status = ST_NONE;
          r.last = 1'b1;
          outs.push_back(r);
        end else begin
          r = outs.pop_back();
          r.last = 1'b1;
          outs.push_back(r);
        end
      end
    endcase
  endfunction

  // Slot that the next check would report as fatal, or -1 if none.
  function automatic int fatal_slot();
    logic [31:0] el;
    for (int i = 0; i < NSLOT; i++) begin
      el = now_cnt - arm_stamp[i];
      if (slot_live[i] && el >= warn_lim && el >= fatal_lim) return i;
    end
    return -1;
  endfunction

  task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
    result_t outs [$];
    int      gap;
    if ($urandom_range(0, 19) == 0) calm = !calm;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_watchdog(it, outs);
    if (typed) begin
      owed_results.push_back(typed_res);
    end else begin
      foreach (outs[i]) owed_results.push_back(outs[i]);
    end
  endtask

  task automatic drain();
    int w;
    start <= 1'b0;
    for (w = 0; w < DRAIN_MAX && owed_results.size() != 0; w++) @(posedge clk_i);
    repeat (IDLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_thresholds(input logic [31:0] warn, input logic [31:0] fatal);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_WARN;
    cfg_wdata_i <= warn;
    @(posedge clk_i);
    cfg_idx_i   <= REG_FATAL;
    cfg_wdata_i <= fatal;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    warn_lim  = warn;
    fatal_lim = fatal;
  endtask

  task automatic run_random(input int count);
    item_t it;
    int    n;
    int    pick;
    int    hit;
    int    free_n;
    int    live_ids [$];
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      it.slot_id = 4'($urandom);
      it.owner = 16'($urandom);
      if (pick < 4) begin
        free_n = 0;
        foreach (slot_live[i]) free_n += slot_live[i] ? 0 : 1;
        it.kind = KIND_ARM;
        repeat (free_n) begin
          it.owner = 16'($urandom);
          send_item(it, 1'b0, '0);
          n++;
        end
      end else if (pick < 38) begin
        it.kind = KIND_ARM;
      end else if (pick < 68) begin
        it.kind = KIND_FEED;
        live_ids.delete();
        foreach (slot_live[i]) if (slot_live[i]) live_ids.push_back(i);
        if (live_ids.size() != 0 && $urandom_range(0, 4) != 0) begin
          it.slot_id = 4'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
        end
      end else if (pick < 84) begin
        it.kind = KIND_TICK;
      end else begin
        it.kind = KIND_CHECK;
        hit = fatal_slot();
        if (hit >= 0) begin
          it.kind = KIND_FEED;
          it.slot_id = 4'(hit);
        end
      end
      send_item(it, 1'b0, '0);
      n++;
    end
  endtask

  function automatic plan_row_t row(input kind_e k, input int id, input int own,
                                    input bit typed, input status_e st, input int slot,
                                    input int sown, input int el);
    plan_row_t p;
    p.it.kind = k;
    p.it.slot_id = 4'(id);
    p.it.owner = 16'(own);
    p.typed = typed;
    p.res.status = st;
    p.res.slot = 4'(slot);
    p.res.slot_owner = 16'(sown);
    p.res.elapsed = 32'(el);
    p.res.last = 1'b1;
    return p;
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_strobe_o) begin
      if (owed_results.size() == 0) begin
        note_fail($sformatf("unexpected result: st=%0d slot=%0d owner=%h el=%0d last=%0b",
                            res_o.status, res_o.slot, res_o.slot_owner, res_o.elapsed,
                            res_o.last));
      end else begin
        want = owed_results.pop_front();
        if (res_o.status !== want.status || res_o.slot !== want.slot ||
            res_o.slot_owner !== want.slot_owner || res_o.elapsed !== want.elapsed ||
            res_o.last !== want.last) begin
          note_fail($sformatf({"result mismatch: expected st=%0d slot=%0d owner=%h el=%0d ",
                               "last=%0b, got st=%0d slot=%0d owner=%h el=%0d last=%0b"},
                              want.status, want.slot, want.slot_owner, want.elapsed,
                              want.last, res_o.status, res_o.slot, res_o.slot_owner,
                              res_o.elapsed, res_o.last));
        end
      end
    end
  end

  initial begin
    item_t       it;
    logic [31:0] warn_set  [5];
    logic [31:0] fatal_set [5];
    int          len_set   [5];
    warn_set  = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd3, 32'd9};
    fatal_set = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd6, 32'd1};
    len_set   = '{75, 60, 40, 70, 30};
    foreach (slot_live[i]) begin
      slot_live[i] = 1'b0;
      arm_stamp[i] = '0;
      arm_owner[i] = '0;
    end
    now_cnt   = '0;
    warn_lim  = WARN_RST;
    fatal_lim = FATAL_RST;
    frozen    = 1'b0;

    plan.push_back(row(KIND_CHECK, 0, 'h0000, 1, ST_NONE, 0, 0, 0));
    plan.push_back(row(KIND_FEED, 0, 'h0000, 1, ST_NOT_ARMED, 0, 0, 0));
    plan.push_back(row(KIND_FEED, 15, 'hFFFF, 1, ST_NOT_ARMED, 15, 0, 0));
    plan.push_back(row(KIND_ARM, 0, 'h0000, 1, ST_ARMED, 0, 'h0000, 0));
    plan.push_back(row(KIND_ARM, 15, 'hFFFF, 1, ST_ARMED, 1, 'hFFFF, 0));
    plan.push_back(row(KIND_TICK, 0, 0, 0, ST_NONE, 0, 0, 0));
    plan.push_back(row(KIND_TICK, 0, 0, 0, ST_NONE, 0, 0, 0));
    plan.push_back(row(KIND_ARM, 3, 'h1234, 1, ST_ARMED, 2, 'h1234, 0));
    plan.push_back(row(KIND_TICK, 0, 0, 0, ST_NONE, 0, 0, 0));
    plan.push_back(row(KIND_TICK, 0, 0, 0, ST_NONE, 0, 0, 0));
    plan.push_back(row(KIND_TICK, 0, 0, 0, ST_NONE, 0, 0, 0));
    plan.push_back(row(KIND_CHECK, 0, 0, 0, ST_NONE, 0, 0, 0));
    plan.push_back(row(KIND_FEED, 1, 0, 1, ST_FED, 1, 'hFFFF, 5));
    plan.push_back(row(KIND_ARM, 0, 'hA5A5, 1, ST_ARMED, 1, 'hA5A5, 0));
    plan.push_back(row(KIND_FEED, 1, 0, 0, ST_NONE, 0, 0, 0));
    plan.push_back(row(KIND_FEED, 1, 0, 1, ST_NOT_ARMED, 1, 0, 0));
    plan.push_back(row(KIND_CHECK, 0, 0, 0, ST_NONE, 0, 0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_item(plan[i].it, plan[i].typed, plan[i].res);

    for (int p = 0; p < 5; p++) begin
      drain();
      set_thresholds(warn_set[p], fatal_set[p]);
      run_random(len_set[p]);
    end

    // Empty the table, then walk a slot past the fatal mark with warn above fatal.
    drain();
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_live[i]) begin
        it.kind = KIND_FEED;
        it.slot_id = 4'(i);
        it.owner = 16'($urandom);
        send_item(it, 1'b0, '0);
      end
    end
    drain();
    set_thresholds(32'd7, 32'd3);
    it.kind = KIND_ARM;
    it.owner = 16'($urandom);
    send_item(it, 1'b0, '0);
    it.kind = KIND_TICK;
    repeat (3) send_item(it, 1'b0, '0);
    it.kind = KIND_CHECK;
    send_item(it, 1'b0, '0);
    it.kind = KIND_TICK;
    repeat (4) send_item(it, 1'b0, '0);
    it.kind = KIND_CHECK;
    send_item(it, 1'b0, '0);
    repeat (20) begin
      it.kind = kind_e'($urandom_range(0, 3));
      it.slot_id = 4'($urandom);
      it.owner = 16'($urandom);
      send_item(it, 1'b0, '0);
    end

    drain();
    if (owed_results.size() != 0) begin
      note_fail($sformatf("%0d expected results never arrived", owed_results.size()));
    end
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
